// File: design/fdss_pkg.sv
// Shared types, codes and SRT recurrence helpers of the single-precision divide/root unit.
package fdss_pkg;

   localparam int DIGITS = 24;

   typedef logic [31:0] word_type;

   localparam word_type HIDDEN_BIT = 32'h0080_0000;
   localparam word_type LOW24_MASK = 32'h00FF_FFFF;
   localparam word_type NEG_LIMIT  = 32'hFF00_0000;

   localparam logic [9:0] DIV_BIAS  = 10'd126;
   localparam logic [8:0] ROOT_BIAS = 9'd127;

   localparam logic [1:0] OP_DIVIDE      = 2'd0;
   localparam logic [1:0] OP_SQRT        = 2'd1;
   localparam logic [1:0] OP_DIVIDE_ROOT = 2'd2;

   // Redundant digit: p means +1, n means -1, neither means 0.
   typedef struct packed {
      logic p;
      logic n;
   } digit_type;

   typedef struct packed {
      word_type  s;
      word_type  c;
      digit_type d;
   } step_type;

   typedef struct packed {
      logic [1:0] op;
      word_type   opa;
      word_type   opb;
      logic       zero;
      logic [7:0] exp_b;
      word_type   root;
      word_type   rem_s;
      word_type   rem_c;
      digit_type  d;
   } sqrt_stage_type;

   typedef struct packed {
      logic [1:0] op;
      logic       sign;
      logic [9:0] expo;
      logic       a_zero;
      word_type   bypass;
      word_type   dv;
      word_type   q;
      word_type   rem_s;
      word_type   rem_c;
      digit_type  d;
   } div_stage_type;

   // Digit as a two's complement word.
   function automatic word_type digit_word(input digit_type d);
      return {{31{d.n}}, d.p | d.n};
   endfunction

   // Partially assimilated estimate: carry added above bit 23, low sum bits OR-ed in.
   function automatic digit_type pick_digit(input word_type s, input word_type c);
      word_type  est;
      digit_type r;
      est = ((s & ~LOW24_MASK) + c) | (s & LOW24_MASK);
      r.p = !est[31] && (est >= HIDDEN_BIT);
      r.n = est[31] && (est < NEG_LIMIT);
      return r;
   endfunction

   // One recurrence step: carry-save add, choose the next digit, shift the remainder.
   function automatic step_type srt_step(input word_type s, input word_type c,
                                         input digit_type d, input word_type add);
      word_type cc;
      word_type u;
      word_type ns;
      word_type nc;
      step_type r;
      cc = c + {31'b0, d.p};
      u  = s ^ cc;
      ns = u ^ add;
      nc = ((s & cc) | (u & add)) << 1;
      if (d.p || d.n) begin
         r.d = pick_digit(ns, nc);
      end else begin
         r.d = pick_digit(s, cc);
      end
      r.s = ns << 1;
      r.c = nc << 1;
      return r;
   endfunction

endpackage

// File: design/fdss_sqrt_cell.sv
// One square-root digit cell: updates the root and carry-save remainder for one digit.
module fdss_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    in_valid,
   input  fdss_pkg::sqrt_stage_type in_stage,
   output logic                    out_valid,
   output fdss_pkg::sqrt_stage_type out_stage
);
   import fdss_pkg::*;

   localparam word_type WEIGHT = 32'd1 << (DIGITS - STEP);

   word_type       plus_w;
   word_type       minus_w;
   word_type       add_w;
   step_type       step;
   sqrt_stage_type stage_in;
   sqrt_stage_type stage_ff;
   logic           valid_ff;

   always_comb begin
      plus_w  = in_stage.root + WEIGHT;
      minus_w = in_stage.root - WEIGHT;
      if (in_stage.d.p) begin
         add_w = ~plus_w;
      end else if (in_stage.d.n) begin
         add_w = minus_w;
      end else begin
         add_w = '0;
      end
      step     = srt_step(in_stage.rem_s, in_stage.rem_c, in_stage.d, add_w);
      stage_in = in_stage;
      if (in_stage.d.p) begin
         stage_in.root = plus_w + WEIGHT;
      end else if (in_stage.d.n) begin
         stage_in.root = minus_w - WEIGHT;
      end
      stage_in.rem_s = step.s;
      stage_in.rem_c = step.c;
      stage_in.d     = step.d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// File: design/fdss_div_cell.sv
// One divide digit cell: adds the digit to the quotient and steps the carry-save remainder.
module fdss_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   in_valid,
   input  fdss_pkg::div_stage_type in_stage,
   output logic                   out_valid,
   output fdss_pkg::div_stage_type out_stage
);
   import fdss_pkg::*;

   word_type      add_w;
   step_type      step;
   div_stage_type stage_in;
   div_stage_type stage_ff;
   logic          valid_ff;

   always_comb begin
      if (in_stage.d.p) begin
         add_w = ~in_stage.dv;
      end else if (in_stage.d.n) begin
         add_w = in_stage.dv;
      end else begin
         add_w = '0;
      end
      step           = srt_step(in_stage.rem_s, in_stage.rem_c, in_stage.d, add_w);
      stage_in       = in_stage;
      stage_in.q     = (in_stage.q << 1) + digit_word(in_stage.d);
      stage_in.rem_s = step.s;
      stage_in.rem_c = step.c;
      stage_in.d     = step.d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// File: design/fp_divide_sqrt_srt_unit.sv
// Top level of the pipelined single-precision divide / square root / divide-by-root unit.
//
//   channel | ports                   | direction | payload
//   --------+-------------------------+-----------+----------------------------------------
//   request | req_tvalid/tready/tdata | in        | tuser: opcode; tdata: operand_a, operand_b
//           | req_tuser               |           |
//   response| rsp_tvalid/tready/tdata | out       | tdata: result_word
//
// Every item walks a row of 24 root cells, then a row of 24 divide cells, then the
// output register. One item is taken per cycle unless req_tready is held low; each cell
// holds one item and takes a new one whenever it is empty or its neighbor moves on, so
// bubbles close up behind a stalled response.
// req_tready drops only when all 49 registers are full and the response is held.
// Reset clears the valid bits of the cells and of the output register; there is no
// clearing pass and no item is lost or duplicated under stalls on either side.
module fp_divide_sqrt_srt_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // [1:0] opcode
   input  logic [63:0] req_tdata,    // [31:0] operand_a, [63:32] operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // [31:0] result_word
);
   import fdss_pkg::*;

   // Root row: cell k holds the item after root digit k.
   logic [DIGITS-1:0] sqrt_valid;
   logic [DIGITS-1:0] sqrt_load;
   sqrt_stage_type    sqrt_out [DIGITS];
   sqrt_stage_type    sqrt_head;

   // Divide row: cell k holds the item after quotient digit k.
   logic [DIGITS-1:0] div_valid;
   logic [DIGITS-1:0] div_load;
   div_stage_type     div_out [DIGITS];
   div_stage_type     div_head;

   // Output register.
   logic              out_load;
   logic              rsp_valid_ff;
   word_type          rsp_data_ff;
   word_type          rsp_data_in;

   // Bridge between the rows.
   word_type          root_fin;
   logic [8:0]        root_exp_sum;
   word_type          root_word;
   word_type          divisor;
   logic [7:0]        sqrt_exp;
   word_type          sqrt_sig;

   // Final normalization.
   word_type          q_fin;
   word_type          q_norm;
   logic [9:0]        e_norm;

   // Advance chain: a stage moves when it is empty or the one after it moves.
   assign out_load = !rsp_valid_ff || rsp_tready;

   generate
      for (genvar k = 0; k < DIGITS; k++) begin : g_load
         if (k == DIGITS - 1) begin : g_last
            assign div_load[k]  = !div_valid[k] || out_load;
            assign sqrt_load[k] = !sqrt_valid[k] || div_load[0];
         end else begin : g_mid
            assign div_load[k]  = !div_valid[k] || div_load[k+1];
            assign sqrt_load[k] = !sqrt_valid[k] || sqrt_load[k+1];
         end
      end
   endgenerate

   assign req_tready = sqrt_load[0];

   // Unpack the radicand: odd exponent shifts by one, even by two.
   always_comb begin
      sqrt_exp = req_tdata[62:55];
      sqrt_sig = {8'b0, 1'b1, req_tdata[54:32]};
      sqrt_head.op    = req_tuser;
      sqrt_head.opa   = req_tdata[31:0];
      sqrt_head.opb   = req_tdata[63:32];
      sqrt_head.zero  = (sqrt_exp == 8'd0);
      sqrt_head.exp_b = sqrt_exp;
      sqrt_head.root  = '0;
      sqrt_head.rem_s = sqrt_exp[0] ? (sqrt_sig << 1) : (sqrt_sig << 2);
      sqrt_head.rem_c = '0;
      sqrt_head.d.p   = 1'b1;
      sqrt_head.d.n   = 1'b0;
   end

   generate
      for (genvar k = 0; k < DIGITS; k++) begin : g_sqrt
         if (k == 0) begin : g_first
            fdss_sqrt_cell #(.STEP(k)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .load      (sqrt_load[k]),
               .in_valid  (req_tvalid),
               .in_stage  (sqrt_head),
               .out_valid (sqrt_valid[k]),
               .out_stage (sqrt_out[k])
            );
         end else begin : g_next
            fdss_sqrt_cell #(.STEP(k)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .load      (sqrt_load[k]),
               .in_valid  (sqrt_valid[k-1]),
               .in_stage  (sqrt_out[k-1]),
               .out_valid (sqrt_valid[k]),
               .out_stage (sqrt_out[k])
            );
         end
      end
   endgenerate

   // Finish the root word, pick the divisor and set up the divide recurrence.
   always_comb begin
      root_fin     = sqrt_out[DIGITS-1].root + (digit_word(sqrt_out[DIGITS-1].d) << 1);
      root_exp_sum = {1'b0, sqrt_out[DIGITS-1].exp_b} + ROOT_BIAS;
      if (sqrt_out[DIGITS-1].zero) begin
         root_word = '0;
      end else begin
         root_word = {1'b0, root_exp_sum[8:1], root_fin[24:2]};
      end
      if (sqrt_out[DIGITS-1].op == OP_DIVIDE_ROOT) begin
         divisor = root_word;
      end else begin
         divisor = sqrt_out[DIGITS-1].opb;
      end
      div_head.op     = sqrt_out[DIGITS-1].op;
      div_head.sign   = sqrt_out[DIGITS-1].opa[31] ^ divisor[31];
      div_head.expo   = {2'b0, sqrt_out[DIGITS-1].opa[30:23]} - {2'b0, divisor[30:23]}
                        + DIV_BIAS;
      div_head.a_zero = (sqrt_out[DIGITS-1].opa[30:23] == 8'd0);
      div_head.bypass = (sqrt_out[DIGITS-1].op == OP_SQRT) ? root_word : '0;
      div_head.dv     = {6'b0, 1'b1, divisor[22:0], 2'b0};
      div_head.q      = '0;
      div_head.rem_s  = {6'b0, 1'b1, sqrt_out[DIGITS-1].opa[22:0], 2'b0};
      div_head.rem_c  = '0;
      div_head.d.p    = 1'b1;
      div_head.d.n    = 1'b0;
   end

   generate
      for (genvar k = 0; k < DIGITS; k++) begin : g_div
         if (k == 0) begin : g_first
            fdss_div_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .load      (div_load[k]),
               .in_valid  (sqrt_valid[DIGITS-1]),
               .in_stage  (div_head),
               .out_valid (div_valid[k]),
               .out_stage (div_out[k])
            );
         end else begin : g_next
            fdss_div_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .load      (div_load[k]),
               .in_valid  (div_valid[k-1]),
               .in_stage  (div_out[k-1]),
               .out_valid (div_valid[k]),
               .out_stage (div_out[k])
            );
         end
      end
   endgenerate

   // Last digit, normalize, then saturate or flush on the exponent range for the divide opcodes.
   always_comb begin
      q_fin = (div_out[DIGITS-1].q << 1) + digit_word(div_out[DIGITS-1].d);
      if (q_fin[31:24] != 8'd0) begin
         q_norm = q_fin >> 1;
         e_norm = div_out[DIGITS-1].expo + 10'd1;
      end else begin
         q_norm = q_fin;
         e_norm = div_out[DIGITS-1].expo;
      end
      case (div_out[DIGITS-1].op)
         OP_DIVIDE, OP_DIVIDE_ROOT: begin
            if (div_out[DIGITS-1].a_zero) begin
               rsp_data_in = {div_out[DIGITS-1].sign, 31'b0};
            end else if ($signed(e_norm) > 10'sd255) begin
               rsp_data_in = {div_out[DIGITS-1].sign, {31{1'b1}}};
            end else if ($signed(e_norm) < 10'sd1) begin
               rsp_data_in = {div_out[DIGITS-1].sign, 31'b0};
            end else begin
               rsp_data_in = {div_out[DIGITS-1].sign, e_norm[7:0], q_norm[22:0]};
            end
         end
         default: begin
            // Square root passes its word; the unused opcode carries zero.
            rsp_data_in = div_out[DIGITS-1].bypass;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= div_valid[DIGITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && div_valid[DIGITS-1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Back-pressure reaches the request side only when every stage is full.
   a_ready_low_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && (&sqrt_valid) && (&div_valid)))
      else $error("request stalled while the pipeline has room");

   // A finished item moving into the output register shows up there next cycle.
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (out_load && div_valid[DIGITS-1]) |=> rsp_tvalid)
      else $error("result lost on its way into the output register");

   // The selector never asserts both digit signs at once.
   a_root_digit: assert property (@(posedge clock) disable iff (reset)
      sqrt_valid[DIGITS-1] |-> $onehot0(sqrt_out[DIGITS-1].d))
      else $error("root digit holds both +1 and -1");

   a_quot_digit: assert property (@(posedge clock) disable iff (reset)
      div_valid[DIGITS-1] |-> $onehot0(div_out[DIGITS-1].d))
      else $error("quotient digit holds both +1 and -1");

   // Leaving reset, no result is presented.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule
